// ----- design/bplt_pkg.sv -----
// package for the board piece list table: item types, square codes,
// memory request structs, controller states and shared constants
// no dependencies
package bplt_pkg;

    localparam int SQ_W     = 6;   // square number, row * side + col
    localparam int SQ_DEPTH = 64;  // entries in the square map
    localparam int IDX_W    = 6;   // list index inside one owner's list
    localparam int CNT_W    = 7;   // list fill count, 0 to 64
    localparam int SLOT_W   = 7;   // owner bit and list index
    localparam int CODE_W   = 8;   // square code width
    localparam int COORD_W  = 4;   // row and column fields of an item
    localparam int POS_W    = 3;   // on-board row or column
    localparam int KIND_IN_W = 32; // kind word field of an item

    localparam int BOARD_SIDE_DEF = 8;
    localparam int LIST_CAP_DEF   = 64;
    localparam int KIND_WIDTH_DEF = 32;

    typedef enum logic {
        OP_PLACE  = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OFF_BOARD = 2'd1,
        ST_CONFLICT  = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        t_op                  op;
        logic [COORD_W-1:0]   row;
        logic [COORD_W-1:0]   col;
        logic                 owner;
        logic [KIND_IN_W-1:0] piece_kind;
    } t_request;

    typedef struct packed {
        t_status            status;
        logic               side;
        logic [CNT_W-1:0]   side_count;
    } t_result;

    // square code: list index, owner, occupied
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             owner;
        logic             occ;
    } t_sq_code;

    typedef struct packed {
        logic             we;
        logic             re;
        logic [SQ_W-1:0]  addr;
        t_sq_code         wdata;
    } t_sq_req;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [SLOT_W-1:0] waddr;
        logic [SLOT_W-1:0] raddr;
    } t_ent_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_MV,
        S_CLR,
        S_OUT
    } t_state;

    function automatic t_sq_code make_code(input logic side, input logic [IDX_W-1:0] idx);
        t_sq_code code;
        code.occ   = 1'b1;
        code.owner = side;
        code.idx   = idx;
        return code;
    endfunction

endpackage

// ----- design/board_piece_list_table_core.sv -----
// board piece list table top level: square map, list entry memory, sequencer
// depends on bplt_pkg, bplt_sqmap, bplt_entry_mem, bplt_ctrl
//
//   channel   valid         stall         payload
//   request   i_in_valid    o_in_stall    i_in_data  (t_request)
//   result    o_out_valid   i_out_stall   o_out_data (t_result)
//
// one item at a time; after acceptance an off-board request goes to S_OUT, place and
// remove of an empty square pass S_SQ, removing a list's last entry S_SQ and S_CLR,
// remove with a move S_SQ, S_MV, S_CLR; S_OUT loads the result once the output register
// is free, then S_IDLE takes the next item; square map port: one read, then up to two writes
// reset clears the counts and the per-square written flags; no sweep
// o_in_stall is high from acceptance until the result enters the output register,
// which holds while i_out_stall is high and frees the sequencer for the next item
module board_piece_list_table_core
    import bplt_pkg::*;
#(
    parameter int BOARD_SIDE = BOARD_SIDE_DEF,
    parameter int LIST_CAP   = LIST_CAP_DEF,
    parameter int KIND_WIDTH = KIND_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_request i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_result  o_out_data
);

    localparam int ENT_W = SQ_W + KIND_WIDTH;

    t_sq_req          sq_req;
    t_sq_code         sq_rdata;
    t_ent_ctl         ent_ctl;
    logic [ENT_W-1:0] ent_wdata;
    logic [ENT_W-1:0] ent_rdata;

    bplt_sqmap u_sqmap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sq_req),
        .o_rdata (sq_rdata)
    );

    bplt_entry_mem #(
        .KIND_WIDTH (KIND_WIDTH)
    ) u_entry_mem (
        .i_clk   (i_clk),
        .i_ctl   (ent_ctl),
        .i_wdata (ent_wdata),
        .o_rdata (ent_rdata)
    );

    bplt_ctrl #(
        .BOARD_SIDE (BOARD_SIDE),
        .LIST_CAP   (LIST_CAP),
        .KIND_WIDTH (KIND_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_sq_req    (sq_req),
        .i_sq_rdata  (sq_rdata),
        .o_ent_ctl   (ent_ctl),
        .o_ent_wdata (ent_wdata),
        .i_ent_rdata (ent_rdata)
    );

    // an accepted item makes the sequencer busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("accepted item did not occupy the sequencer");

    // every list entry write comes with a square map write
    a_entry_with_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ent_ctl.we |-> sq_req.we)
        else $error("entry write without square map update");

    // square map port is never asked to read and write at once
    a_sq_single_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(sq_req.we && sq_req.re))
        else $error("square map read and write in the same cycle");

    // reading the last entry is always followed by the move write
    a_move_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ent_ctl.re |=> ent_ctl.we && sq_req.we)
        else $error("last entry read without move write");

endmodule

// ----- design/bplt_sqmap.sv -----
// square map memory: 64 codes, one access per cycle, registered read
// every square reads as empty until first written; uses bplt_pkg
module bplt_sqmap
    import bplt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_sq_req             i_req,
    output t_sq_code            o_rdata
);

    logic [CODE_W-1:0]   r_mem [SQ_DEPTH];
    logic [SQ_DEPTH-1:0] r_written;
    logic [CODE_W-1:0]   r_rdata;
    logic                r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rvalid  <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_written[i_req.addr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rvalid <= r_written[i_req.addr];
            end
        end
    end

    // never written squares read as the empty code
    assign o_rdata = r_rvalid ? t_sq_code'(r_rdata) : t_sq_code'('0);

endmodule

// ----- design/bplt_entry_mem.sv -----
// list entry memory: 128 slots of square number and kind word, owner in the top
// address bit; one write and one registered read per cycle; uses bplt_pkg
module bplt_entry_mem
    import bplt_pkg::*;
#(
    parameter int KIND_WIDTH = KIND_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  t_ent_ctl                   i_ctl,
    input  logic [SQ_W+KIND_WIDTH-1:0] i_wdata,
    output logic [SQ_W+KIND_WIDTH-1:0] o_rdata
);

    localparam int ENT_W = SQ_W + KIND_WIDTH;
    localparam int SLOTS = 2 ** SLOT_W;

    logic [ENT_W-1:0] r_mem [SLOTS];
    logic [ENT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_ctl.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/bplt_ctrl.sv -----
// request sequencer: owner counts, square map and entry memory
// read-modify-write steps, result register; uses bplt_pkg
module bplt_ctrl
    import bplt_pkg::*;
#(
    parameter int BOARD_SIDE = BOARD_SIDE_DEF,
    parameter int LIST_CAP   = LIST_CAP_DEF,
    parameter int KIND_WIDTH = KIND_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  t_request                   i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output t_result                    o_out_data,
    output t_sq_req                    o_sq_req,
    input  t_sq_code                   i_sq_rdata,
    output t_ent_ctl                   o_ent_ctl,
    output logic [SQ_W+KIND_WIDTH-1:0] o_ent_wdata,
    input  logic [SQ_W+KIND_WIDTH-1:0] i_ent_rdata
);

    localparam int ENT_W = SQ_W + KIND_WIDTH;
    localparam logic [COORD_W-1:0] SIDE_C = COORD_W'(BOARD_SIDE);
    localparam logic [SQ_W-1:0]    SIDE_M = SQ_W'(BOARD_SIDE);
    localparam logic [CNT_W-1:0]   CAP_C  = CNT_W'(LIST_CAP);

    t_state            r_state, n_state;
    t_request          r_req, n_req;
    logic [SQ_W-1:0]   r_sq, n_sq;
    logic              r_side, n_side;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_cnt [2];
    logic [CNT_W-1:0]  n_cnt [2];
    t_result           r_res, n_res;
    t_result           r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic              in_on_board;
    logic [SQ_W-1:0]   in_sq;
    logic [KIND_WIDTH-1:0] kind_st;

    assign in_on_board = (i_in_data.row < SIDE_C) && (i_in_data.col < SIDE_C);
    assign in_sq = SQ_W'(i_in_data.row[POS_W-1:0]) * SIDE_M + SQ_W'(i_in_data.col[POS_W-1:0]);

    if (KIND_WIDTH <= KIND_IN_W) begin : g_kind_trunc
        assign kind_st = r_req.piece_kind[KIND_WIDTH-1:0];
    end else begin : g_kind_ext
        assign kind_st = {{(KIND_WIDTH-KIND_IN_W){1'b0}}, r_req.piece_kind};
    end

    always_comb begin
        logic [CNT_W-1:0] cnt_sel;
        logic [IDX_W-1:0] last_idx;
        logic [SQ_W-1:0]  moved_sq;

        n_state     = r_state;
        n_req       = r_req;
        n_sq        = r_sq;
        n_side      = r_side;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_sq_req    = '0;
        o_ent_ctl   = '0;
        o_ent_wdata = '0;
        cnt_sel     = '0;
        last_idx    = '0;
        moved_sq    = i_ent_rdata[ENT_W-1 -: SQ_W];

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req = i_in_data;
                    n_sq  = in_sq;
                    if (in_on_board) begin
                        o_sq_req.re   = 1'b1;
                        o_sq_req.addr = in_sq;
                        n_state       = S_SQ;
                    end else begin
                        n_res.status = ST_OFF_BOARD;
                        if (i_in_data.op == OP_PLACE) begin
                            n_res.side       = i_in_data.owner;
                            n_res.side_count = r_cnt[i_in_data.owner];
                        end else begin
                            n_res.side       = 1'b0;
                            n_res.side_count = '0;
                        end
                        n_state = S_OUT;
                    end
                end
            end
            S_SQ: begin
                n_state = S_OUT;
                if (r_req.op == OP_PLACE) begin
                    cnt_sel          = r_cnt[r_req.owner];
                    n_res.side       = r_req.owner;
                    n_res.side_count = cnt_sel;
                    if (i_sq_rdata.occ) begin
                        n_res.status = ST_CONFLICT;
                    end else if (cnt_sel >= CAP_C) begin
                        n_res.status = ST_FULL;
                    end else begin
                        o_ent_ctl.we   = 1'b1;
                        o_ent_ctl.waddr = {r_req.owner, cnt_sel[IDX_W-1:0]};
                        o_ent_wdata    = {r_sq, kind_st};
                        o_sq_req.we    = 1'b1;
                        o_sq_req.addr  = r_sq;
                        o_sq_req.wdata = make_code(r_req.owner, cnt_sel[IDX_W-1:0]);
                        n_cnt[r_req.owner] = cnt_sel + 1'b1;
                        n_res.status     = ST_DONE;
                        n_res.side_count = cnt_sel + 1'b1;
                    end
                end else begin
                    if (!i_sq_rdata.occ) begin
                        n_res.status     = ST_CONFLICT;
                        n_res.side       = 1'b0;
                        n_res.side_count = '0;
                    end else begin
                        cnt_sel  = r_cnt[i_sq_rdata.owner];
                        // an empty list wraps to the top slot
                        last_idx = IDX_W'(cnt_sel - 1'b1);
                        n_side   = i_sq_rdata.owner;
                        n_idx    = i_sq_rdata.idx;
                        if (i_sq_rdata.idx != last_idx) begin
                            o_ent_ctl.re    = 1'b1;
                            o_ent_ctl.raddr = {i_sq_rdata.owner, last_idx};
                            n_state         = S_MV;
                        end else begin
                            n_state = S_CLR;
                        end
                    end
                end
            end
            S_MV: begin
                // last entry fills the freed slot, its square gets the new index
                o_ent_ctl.we    = 1'b1;
                o_ent_ctl.waddr = {r_side, r_idx};
                o_ent_wdata     = i_ent_rdata;
                o_sq_req.we     = 1'b1;
                o_sq_req.addr   = moved_sq;
                o_sq_req.wdata  = make_code(r_side, r_idx);
                n_state         = S_CLR;
            end
            S_CLR: begin
                cnt_sel = r_cnt[r_side];
                if (cnt_sel != '0) begin
                    cnt_sel = cnt_sel - 1'b1;
                end
                n_cnt[r_side]    = cnt_sel;
                o_sq_req.we      = 1'b1;
                o_sq_req.addr    = r_sq;
                o_sq_req.wdata   = '0;
                n_res.status     = ST_DONE;
                n_res.side       = r_side;
                n_res.side_count = cnt_sel;
                n_state          = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '{default: '0};
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_sq   <= n_sq;
        r_side <= n_side;
        r_idx  <= n_idx;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
